>>> design/spq_pkg.sv
// shared types and constants for the sorted priority queue
// used by spq_cell and sorted_priority_queue; no dependencies
package spq_pkg;

    localparam int SPQ_CAPACITY = 16;
    localparam int DATA_W       = 32;
    localparam int OCC_W        = 5;

    localparam logic signed [DATA_W-1:0] EMPTY_MARK = 32'sh7FFF_FFFF;

    typedef enum logic [0:0] {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] prio;
        logic signed [DATA_W-1:0] value;
    } entry_t;

    typedef struct packed {
        opcode_t                  opcode;
        logic signed [DATA_W-1:0] priority_req;
        logic signed [DATA_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] head_value;
        logic signed [DATA_W-1:0] head_priority;
        logic                     is_empty;
        logic [OCC_W-1:0]         occupancy;
        status_t                  status;
    } out_item_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic load;
        logic insert;
    } cell_ctrl_t;

endpackage

>>> design/sorted_priority_queue.sv
// Bounded priority queue built as a chain of CAPACITY cells kept in ascending
// order of priority, equal priorities in arrival order. Every cell compares its
// key with the broadcast key of an insert in the same cycle; higher keys shift
// one place to the tail; a removal shifts the whole chain one place to the head.
// One item is taken per clock cycle and its result appears in the output
// register on the next cycle; a new item is accepted in the cycle in which the
// pending result is taken, so the sustained rate is one item per cycle. An
// insert into a full queue and a removal from an empty queue leave the entries
// unchanged and are reported in the status field. No clearing pass after reset.
module sorted_priority_queue #(
    parameter int CAPACITY = spq_pkg::SPQ_CAPACITY
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  spq_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output spq_pkg::out_item_t  out_data
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_data_reg, out_data_next;

    logic             accept;
    logic             full, empty;
    status_t          status;
    cell_ctrl_t       ctrl;
    entry_t           new_entry;
    entry_t           cell_entry [CAPACITY];
    entry_t           cell_next  [CAPACITY];
    logic             cell_after [CAPACITY];
    logic [CNT_W+OCC_W-1:0] count_ext;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign new_entry = '{prio: in_data.priority_req, value: in_data.value};

    always_comb
    begin
        status      = ST_OK;
        ctrl.insert = (in_data.opcode == OP_INSERT);
        ctrl.load   = 1'b0;
        count_next  = count_reg;
        case (in_data.opcode)
            OP_INSERT:
            begin
                if (full)
                    status = ST_FULL;
                else
                begin
                    ctrl.load  = accept;
                    count_next = accept ? count_reg + 1'b1 : count_reg;
                end
            end
            OP_REMOVE:
            begin
                if (empty)
                    status = ST_EMPTY;
                else
                begin
                    ctrl.load  = accept;
                    count_next = accept ? count_reg - 1'b1 : count_reg;
                end
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            entry_t prev_e;
            entry_t next_e;
            logic   prev_a;

            if (g == 0)
            begin : g_first
                assign prev_e = new_entry;
                assign prev_a = 1'b1;
            end
            else
            begin : g_mid
                assign prev_e = cell_entry[g-1];
                assign prev_a = cell_after[g-1];
            end

            if (g == CAPACITY - 1)
            begin : g_last
                assign next_e = cell_entry[g];
            end
            else
            begin : g_body
                assign next_e = cell_entry[g+1];
            end

            spq_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .occupied   (CNT_W'(g) < count_reg),
                .new_entry  (new_entry),
                .prev_entry (prev_e),
                .prev_after (prev_a),
                .next_entry (next_e),
                .entry      (cell_entry[g]),
                .entry_next (cell_next[g]),
                .after      (cell_after[g])
            );
        end
    endgenerate

    assign count_ext = {{OCC_W{1'b0}}, count_next};

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (accept)
        begin
            out_valid_next          = 1'b1;
            out_data_next.is_empty  = (count_next == '0);
            out_data_next.occupancy = count_ext[OCC_W-1:0];
            out_data_next.status    = status;
            if (count_next == '0)
            begin
                out_data_next.head_value    = EMPTY_MARK;
                out_data_next.head_priority = EMPTY_MARK;
            end
            else
            begin
                out_data_next.head_value    = cell_next[0].value;
                out_data_next.head_priority = cell_next[0].prio;
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("item accepted while result stalled");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.is_empty == (count_reg == '0)))
        else $error("empty flag disagrees with entry count");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status == ST_FULL) |-> full)
        else $error("full status reported on a queue with room");

    a_remove_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_data.opcode == OP_REMOVE && !empty)
            |=> count_reg == $past(count_reg) - 1'b1)
        else $error("removal did not drop the entry count");

endmodule

>>> design/spq_cell.sv
// one slot of the sorted chain: holds an entry, compares it with the new key
// and takes its own, the new or a neighbour's entry; depends on spq_pkg
module spq_cell (
    input  logic                clk,
    input  spq_pkg::cell_ctrl_t ctrl,
    input  logic                occupied,
    input  spq_pkg::entry_t     new_entry,
    input  spq_pkg::entry_t     prev_entry,
    input  logic                prev_after,
    input  spq_pkg::entry_t     next_entry,
    output spq_pkg::entry_t     entry,
    output spq_pkg::entry_t     entry_next,
    output logic                after
);
    import spq_pkg::*;

    entry_t entry_reg;

    // new key goes behind this slot when the slot is occupied and holds an equal or lower key
    assign after = occupied && (entry_reg.prio <= new_entry.prio);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.load)
        begin
            if (ctrl.insert)
            begin
                if (after)
                    entry_next = entry_reg;
                else if (prev_after)
                    entry_next = new_entry;
                else
                    entry_next = prev_entry;
            end
            else
            begin
                entry_next = next_entry;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

>>> bench/spq_checker.sv
// result checker for the sorted priority queue: watches both channels, keeps
// its own sorted copy of the entries and compares every result with it
// depends on spq_pkg
module spq_checker #(
    parameter int CAPACITY = spq_pkg::SPQ_CAPACITY
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  spq_pkg::in_item_t  in_data,
    input  logic               out_valid,
    input  logic               out_ready,
    input  spq_pkg::out_item_t out_data,
    output int                 fail_count,
    output int                 pending,
    output int                 checked_count,
    output int                 dropped_count,
    output int                 underrun_count
);
    import spq_pkg::*;

    entry_t    sorted_entries [CAPACITY];
    int        held;
    out_item_t due_results [$];
    int        errors = 0;

    assign fail_count = errors;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("spq_checker: %s: got %0d, expected %0d", what, got, want);
        errors++;
    endtask

    // sorted insert with ties behind, or head removal, then the head report
    task automatic apply_item(input in_item_t it, output out_item_t res);
        int      slot;
        status_t st;
        st = ST_OK;
        if (it.opcode == OP_INSERT)
        begin
            if (held >= CAPACITY)
            begin
                st = ST_FULL;
                dropped_count++;
            end
            else
            begin
                slot = 0;
                while (slot < held
                       && $signed(sorted_entries[slot].prio) <= $signed(it.priority_req))
                    slot++;
                for (int k = held; k > slot; k--)
                    sorted_entries[k] = sorted_entries[k - 1];
                sorted_entries[slot].prio  = it.priority_req;
                sorted_entries[slot].value = it.value;
                held++;
            end
        end
        else if (held == 0)
        begin
            st = ST_EMPTY;
            underrun_count++;
        end
        else
        begin
            for (int k = 1; k < held; k++)
                sorted_entries[k - 1] = sorted_entries[k];
            held--;
        end

        if (held == 0)
        begin
            res.head_value    = EMPTY_MARK;
            res.head_priority = EMPTY_MARK;
            res.is_empty      = 1'b1;
        end
        else
        begin
            res.head_value    = sorted_entries[0].value;
            res.head_priority = sorted_entries[0].prio;
            res.is_empty      = 1'b0;
        end
        res.occupancy = OCC_W'(held);
        res.status    = st;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        out_item_t next_res;
        if (!rst_n)
        begin
            held = 0;
            due_results.delete();
            pending = 0;
        end
        else
        begin
            // the result leaving now always belongs to an older item
            if (out_valid && out_ready)
            begin
                if (due_results.size() == 0)
                begin
                    report_mismatch("result with nothing expected", out_data.occupancy, -1);
                end
                else
                begin
                    want = due_results.pop_front();
                    checked_count++;
                    if (out_data.head_value !== want.head_value)
                        report_mismatch("head_value", out_data.head_value, want.head_value);
                    if (out_data.head_priority !== want.head_priority)
                        report_mismatch("head_priority", out_data.head_priority,
                                        want.head_priority);
                    if (out_data.is_empty !== want.is_empty)
                        report_mismatch("is_empty", out_data.is_empty, want.is_empty);
                    if (out_data.occupancy !== want.occupancy)
                        report_mismatch("occupancy", out_data.occupancy, want.occupancy);
                    if (out_data.status !== want.status)
                        report_mismatch("status", out_data.status, want.status);
                end
            end
            if (in_valid && in_ready)
            begin
                apply_item(in_data, next_res);
                due_results.push_back(next_res);
            end
            pending = due_results.size();
        end
    end

endmodule

>>> bench/tb.sv
// top-level testbench for sorted_priority_queue: drives directed and random
// inserts and removals with random stalls on both sides
// depends on spq_pkg, spq_checker and the design
module tb;
    import spq_pkg::*;

    localparam int ITEM_TARGET = 1450;
    localparam int CALM_TAIL   = 150;
    localparam int STALL_LIMIT = 1000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    int fail_count;
    int pending;
    int checked_count;
    int dropped_count;
    int underrun_count;
    int sent = 0;
    int quiet_cycles = 0;
    bit calm = 0;

    sorted_priority_queue #(.CAPACITY(SPQ_CAPACITY)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    spq_checker #(.CAPACITY(SPQ_CAPACITY)) queue_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_data       (out_data),
        .fail_count     (fail_count),
        .pending        (pending),
        .checked_count  (checked_count),
        .dropped_count  (dropped_count),
        .underrun_count (underrun_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(input opcode_t op, input logic signed [31:0] prio,
                             input logic signed [31:0] val);
        in_data  <= '{opcode: op, priority_req: prio, value: val};
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        sent++;
        @(negedge clk);
    endtask

    task automatic sender_pause(input int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(negedge clk);
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
    endtask

    function automatic logic signed [31:0] pick_priority();
        case ($urandom_range(0, 5))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            2, 3:    return $urandom_range(0, 8) - 4;    // narrow range, many ties
            default: return $urandom;
        endcase
    endfunction

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // receiver side: random stall bursts until the calm tail
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 2) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        int      mode;
        int      span;
        int      insert_pct;
        bit      sender_idles;
        opcode_t op;

        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_data  = '0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: removal on empty, extremes, ties, fill to full, dropped insert
        send_item(OP_REMOVE, 32'sh1234_5678, -1);
        send_item(OP_INSERT, 32'sh7FFF_FFFF, 32'sh8000_0000);
        send_item(OP_INSERT, 32'sh8000_0000, 32'sh7FFF_FFFF);
        send_item(OP_INSERT, 0, 1);
        send_item(OP_INSERT, 0, 2);
        send_item(OP_INSERT, 0, 3);
        send_item(OP_INSERT, -1, 32'shFFFF_FFFF);
        send_item(OP_INSERT, 32'sh7FFF_FFFF, 0);
        repeat (9) send_item(OP_INSERT, pick_priority(), pick_value());
        send_item(OP_INSERT, 5, 5);
        repeat (5) send_item(OP_REMOVE, $urandom, $urandom);
        wait_for_drain();

        // random phases: filling, draining and mixed runs
        while (sent < ITEM_TARGET)
        begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(8, 48);
            case (mode)
                0:       insert_pct = 85;
                1:       insert_pct = 15;
                default: insert_pct = 50;
            endcase
            sender_idles = $urandom_range(0, 2) != 0;
            if (!calm && $urandom_range(0, 9) == 0)
                wait_for_drain();
            for (int n = 0; n < span && sent < ITEM_TARGET; n++)
            begin
                if (sent >= ITEM_TARGET - CALM_TAIL)
                    calm = 1'b1;
                op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
                if (sender_idles && !calm && $urandom_range(0, 3) == 0)
                    sender_pause($urandom_range(1, 17));
                send_item(op, pick_priority(), pick_value());
            end
        end

        wait_for_drain();
        repeat (8) @(negedge clk);
        $display("tb: %0d items sent, %0d results compared", sent, checked_count);
        $display("tb: %0d inserts refused when full, %0d removals on an empty queue",
                 dropped_count, underrun_count);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> sim.f
design/spq_pkg.sv
design/spq_cell.sv
design/sorted_priority_queue.sv
bench/spq_checker.sv
bench/tb.sv
